// File: design/rlrs_pkg.sv
// types and codes shared by the recovery supervisor modules
package rlrs_pkg;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [1:0] CMD_NONE    = 2'd0;
    localparam logic [1:0] CMD_START   = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [1:0] ACT_NONE      = 2'd0;
    localparam logic [1:0] ACT_STARTED   = 2'd1;
    localparam logic [1:0] ACT_RESTARTED = 2'd2;
    localparam logic [1:0] ACT_DISABLED  = 2'd3;

    localparam logic [1:0] EVT_NONE    = 2'd0;
    localparam logic [1:0] EVT_REFUSED = 2'd1;
    localparam logic [1:0] EVT_LIMIT   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_AUTO_RECOVER_EN = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SECONDS  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RESTARTS    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLIENT_TIMEOUT  = 8'd3;

    typedef struct packed {
        logic        auto_recover_en;
        logic [15:0] window_seconds;
        logic [7:0]  max_restarts;
        logic [15:0] client_timeout_seconds;
    } sup_cfg_t;

    typedef struct packed {
        logic        service_alive;
        logic        port_listening;
        logic [7:0]  client_count;
        logic [31:0] timestamp_seconds;
    } check_t;

    typedef struct packed {
        logic        disabled_latch;
        logic [31:0] window_begin;
        logic [7:0]  restart_counter;
        logic [31:0] total_counter;
        logic        no_client_armed;
        logic [31:0] no_client_start;
        logic [1:0]  action_code;
    } sup_state_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [1:0]  action_state;
        logic [1:0]  disable_event;
        logic [7:0]  window_restarts;
        logic [31:0] total_recoveries;
    } result_t;

endpackage

// File: design/rlrs_step.sv
// decision logic for one health check: next supervisor state and result
module rlrs_step
    import rlrs_pkg::*;
#(
    parameter int DEFAULT_WINDOW_SECONDS = 60,
    parameter int DEFAULT_MAX_RESTARTS   = 3,
    parameter int DEFAULT_CLIENT_TIMEOUT = 30
)
(
    input  sup_cfg_t   cfg,
    input  sup_state_t state_cur,
    input  check_t     check,
    output sup_state_t state_new,
    output result_t    result
);

    logic [15:0] win;
    logic [7:0]  limit;
    logic [15:0] tmo;
    logic [31:0] win_elapsed;
    logic [31:0] nc_elapsed;
    logic        healthy;
    logic        refresh;
    logic [7:0]  rc_eff;
    logic [7:0]  rc_inc;
    logic        allows;
    logic        nc_due;
    logic        attempt;

    assign win   = (cfg.window_seconds != 16'd0) ? cfg.window_seconds
                                                 : 16'(DEFAULT_WINDOW_SECONDS);
    assign limit = (cfg.max_restarts != 8'd0) ? cfg.max_restarts : 8'(DEFAULT_MAX_RESTARTS);
    assign tmo   = (cfg.client_timeout_seconds != 16'd0) ? cfg.client_timeout_seconds
                                                         : 16'(DEFAULT_CLIENT_TIMEOUT);

    assign win_elapsed = check.timestamp_seconds - state_cur.window_begin;
    assign nc_elapsed  = check.timestamp_seconds - state_cur.no_client_start;

    assign healthy = check.service_alive && check.port_listening
                     && (check.client_count != 8'd0);
    assign refresh = win_elapsed >= {16'd0, win};
    assign rc_eff  = refresh ? 8'd0 : state_cur.restart_counter;
    assign rc_inc  = rc_eff + 8'd1;
    assign allows  = rc_eff < limit;
    assign nc_due  = state_cur.no_client_armed && (nc_elapsed >= {16'd0, tmo});

    // recovery wanted: start, restart on port loss, or no-client timeout
    assign attempt = !healthy && cfg.auto_recover_en && !state_cur.disabled_latch
                     && (!check.service_alive || !check.port_listening || nc_due);

    always_comb
    begin
        logic [1:0] code;
        code      = check.service_alive ? CMD_RESTART : CMD_START;
        state_new = state_cur;
        result.command       = CMD_NONE;
        result.disable_event = EVT_NONE;

        if (healthy)
        begin
            state_new.no_client_armed = 1'b0;
            if (!state_cur.disabled_latch && cfg.auto_recover_en
                && state_cur.action_code != ACT_DISABLED)
            begin
                state_new.action_code = ACT_NONE;
            end
        end
        else if (!cfg.auto_recover_en || state_cur.disabled_latch)
        begin
            if (state_cur.disabled_latch)
            begin
                state_new.action_code = ACT_DISABLED;
            end
        end
        else if (attempt)
        begin
            if (refresh)
            begin
                state_new.window_begin = check.timestamp_seconds;
            end
            state_new.restart_counter = rc_eff;
            if (!allows)
            begin
                state_new.disabled_latch = 1'b1;
                state_new.action_code    = ACT_DISABLED;
                result.disable_event     = EVT_REFUSED;
            end
            else
            begin
                result.command            = code;
                state_new.action_code     = code;
                state_new.restart_counter = rc_inc;
                state_new.total_counter   = state_cur.total_counter + 32'd1;
                state_new.no_client_armed = 1'b0;
                if (rc_inc >= limit)
                begin
                    state_new.disabled_latch = 1'b1;
                    result.disable_event     = EVT_LIMIT;
                end
            end
        end
        else if (!state_cur.no_client_armed)
        begin
            // first check without clients starts the timer
            state_new.no_client_armed = 1'b1;
            state_new.no_client_start = check.timestamp_seconds;
        end

        result.action_state     = state_new.action_code;
        result.window_restarts  = state_new.restart_counter;
        result.total_recoveries = state_new.total_counter;
    end

endmodule

// File: design/rate_limited_recovery_supervisor_unit.sv
// top level of the rate-limited recovery supervisor
// registered in the input register, then the result register, which m_tready can stall
// throughput: one request per cycle unless m_tready stalls, bounded by the state loop
// a request is accepted while a result waits for m_tready, if the input register is empty
// reset: rst_n clears all supervisor state, configuration and valid flags at once
module rate_limited_recovery_supervisor_unit
    import rlrs_pkg::*;
#(
    parameter int DEFAULT_WINDOW_SECONDS = 60,
    parameter int DEFAULT_MAX_RESTARTS   = 3,
    parameter int DEFAULT_CLIENT_TIMEOUT = 30
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // service_alive, port_listening, client_count[7:0], timestamp_seconds[31:0], zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // command[1:0], action_state[1:0], disable_event[1:0], window_restarts[7:0],
    // total_recoveries[31:0], zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    sup_cfg_t   cfg_reg;
    sup_state_t state_reg;
    sup_state_t state_next;
    check_t     in_reg;
    logic       in_valid_reg;
    result_t    out_reg;
    result_t    out_next;
    logic       out_valid_reg;
    logic       advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_AUTO_RECOVER_EN: cfg_reg.auto_recover_en        <= cfg_data[0];
                CFG_WINDOW_SECONDS:  cfg_reg.window_seconds         <= cfg_data;
                CFG_MAX_RESTARTS:    cfg_reg.max_restarts           <= cfg_data[7:0];
                CFG_CLIENT_TIMEOUT:  cfg_reg.client_timeout_seconds <= cfg_data;
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg.service_alive     <= s_tdata[0];
            in_reg.port_listening    <= s_tdata[1];
            in_reg.client_count      <= s_tdata[9:2];
            in_reg.timestamp_seconds <= s_tdata[41:10];
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    rlrs_step #(
        .DEFAULT_WINDOW_SECONDS (DEFAULT_WINDOW_SECONDS),
        .DEFAULT_MAX_RESTARTS   (DEFAULT_MAX_RESTARTS),
        .DEFAULT_CLIENT_TIMEOUT (DEFAULT_CLIENT_TIMEOUT)
    ) u_step (
        .cfg       (cfg_reg),
        .state_cur (state_reg),
        .check     (in_reg),
        .state_new (state_next),
        .result    (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.total_recoveries, out_reg.window_restarts,
                       out_reg.disable_event, out_reg.action_state, out_reg.command};

`ifndef ASSERT_OFF
    a_latch_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.disabled_latch |=> state_reg.disabled_latch)
        else $error("disabled latch cleared");

    a_cmd_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && out_next.command != CMD_NONE)
        |=> state_reg.total_counter == $past(state_reg.total_counter) + 32'd1)
        else $error("issued command not counted");

    a_refuse_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.disable_event == EVT_REFUSED)
        |-> (out_reg.command == CMD_NONE && out_reg.action_state == ACT_DISABLED))
        else $error("refused request carries a command");

    a_state_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> state_reg == $past(state_reg))
        else $error("state changed without a request");
`endif

endmodule

// File: test/tb_rate_limited_recovery_supervisor_unit.sv
// testbench for the recovery supervisor: queued checks, predicted results, field compares
`timescale 1ns / 100ps

module tb_rate_limited_recovery_supervisor_unit;
    import rlrs_pkg::*;

    localparam int DEF_WINDOW  = 60;
    localparam int DEF_MAX     = 3;
    localparam int DEF_TIMEOUT = 30;
    localparam int STALL_LEN   = 300;
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_UNUSED = 8'd200;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    rate_limited_recovery_supervisor_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    check_t     pending_checks[$];
    result_t    expected_results[$];
    check_t     next_check;
    check_t     seen_check;
    result_t    seen_result;
    result_t    predicted;
    sup_cfg_t   regs = '0;
    sup_state_t sup = '0;

    logic        in_taken = 1'b0;
    int          mismatches = 0;
    int          src_idle = 21;
    int          sink_idle = 21;
    logic        stall_req = 1'b0;
    logic        stall_ack = 1'b0;
    int          stall_left = 0;
    logic [31:0] ts_now = '0;
    int          no_client_run = 0;
    logic        latch_by_refusal;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // one attempt or a refusal by the window limit
    task automatic recover(input logic [31:0] now, input logic [1:0] code,
                           inout logic [1:0] cmd, inout logic [1:0] evt);
        logic [31:0] win;
        logic [7:0]  lim;
        win = (regs.window_seconds != 0) ? 32'(regs.window_seconds) : 32'(DEF_WINDOW);
        lim = (regs.max_restarts != 0) ? regs.max_restarts : 8'(DEF_MAX);
        if ((now - sup.window_begin) >= win)
        begin
            sup.window_begin = now;
            sup.restart_counter = '0;
        end
        if (sup.restart_counter >= lim)
        begin
            sup.disabled_latch = 1'b1;
            sup.action_code = ACT_DISABLED;
            evt = EVT_REFUSED;
        end
        else
        begin
            cmd = code;
            sup.action_code = code;
            sup.restart_counter = sup.restart_counter + 8'd1;
            sup.total_counter = sup.total_counter + 32'd1;
            if (sup.restart_counter >= lim)
            begin
                sup.disabled_latch = 1'b1;
                evt = EVT_LIMIT;
            end
            sup.no_client_armed = 1'b0;
        end
    endtask

    task automatic supervise(input check_t chk, output result_t res);
        logic [1:0]  cmd;
        logic [1:0]  evt;
        logic [31:0] tmo;
        logic [31:0] now;
        cmd = CMD_NONE;
        evt = EVT_NONE;
        now = chk.timestamp_seconds;
        if (chk.service_alive && chk.port_listening && chk.client_count != 0)
        begin
            sup.no_client_armed = 1'b0;
            if (!sup.disabled_latch && regs.auto_recover_en && sup.action_code != ACT_DISABLED)
                sup.action_code = ACT_NONE;
        end
        else if (!regs.auto_recover_en || sup.disabled_latch)
        begin
            if (sup.disabled_latch)
                sup.action_code = ACT_DISABLED;
        end
        else if (!chk.service_alive)
            recover(now, CMD_START, cmd, evt);
        else if (!chk.port_listening)
            recover(now, CMD_RESTART, cmd, evt);
        else
        begin
            tmo = (regs.client_timeout_seconds != 0) ? 32'(regs.client_timeout_seconds)
                                                     : 32'(DEF_TIMEOUT);
            if (!sup.no_client_armed)
            begin
                sup.no_client_armed = 1'b1;
                sup.no_client_start = now;
            end
            else if ((now - sup.no_client_start) >= tmo)
                recover(now, CMD_RESTART, cmd, evt);
        end
        res.command = cmd;
        res.action_state = sup.action_code;
        res.disable_event = evt;
        res.window_restarts = sup.restart_counter;
        res.total_recoveries = sup.total_counter;
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (pending_checks.size() != 0 && $urandom_range(99) >= src_idle)
            begin
                next_check = pending_checks.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {6'd0, next_check.timestamp_seconds, next_check.client_count,
                            next_check.port_listening, next_check.service_alive};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end
            else if (stall_req != stall_ack)
            begin
                stall_ack <= stall_req;
                stall_left <= STALL_LEN;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= sink_idle);
        end
    end

    // monitor and predictor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                seen_result.command = m_tdata[1:0];
                seen_result.action_state = m_tdata[3:2];
                seen_result.disable_event = m_tdata[5:4];
                seen_result.window_restarts = m_tdata[13:6];
                seen_result.total_recoveries = m_tdata[45:14];
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
                else
                begin
                    predicted = expected_results.pop_front();
                    check_field("command", 32'(seen_result.command), 32'(predicted.command));
                    check_field("action_state", 32'(seen_result.action_state),
                                32'(predicted.action_state));
                    check_field("disable_event", 32'(seen_result.disable_event),
                                32'(predicted.disable_event));
                    check_field("window_restarts", 32'(seen_result.window_restarts),
                                32'(predicted.window_restarts));
                    check_field("total_recoveries", seen_result.total_recoveries,
                                predicted.total_recoveries);
                end
            end
            if (s_tvalid && s_tready)
            begin
                seen_check.service_alive = s_tdata[0];
                seen_check.port_listening = s_tdata[1];
                seen_check.client_count = s_tdata[9:2];
                seen_check.timestamp_seconds = s_tdata[41:10];
                supervise(seen_check, predicted);
                expected_results.push_back(predicted);
            end
        end
        in_taken <= rst_n && s_tvalid && s_tready;
    end

    task automatic queue_check(input logic alive, input logic port, input logic [7:0] clients,
                               input logic [31:0] ts);
        check_t c;
        c.service_alive = alive;
        c.port_listening = port;
        c.client_count = clients;
        c.timestamp_seconds = ts;
        pending_checks.push_back(c);
    endtask

    task automatic queue_random(input int n);
        int          r;
        logic [31:0] step;
        logic        alive;
        logic        port;
        logic [7:0]  clients;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 80)
                step = $urandom_range(12, 0);
            else if (r < 95)
                step = $urandom_range(70000, 0);
            else
                step = $urandom;
            ts_now = ts_now + step;
            if (no_client_run == 0 && $urandom_range(99) < 12)
                no_client_run = $urandom_range(10, 4);
            if (no_client_run > 0)
            begin
                no_client_run--;
                alive = 1'b1;
                port = 1'b1;
                clients = 8'd0;
            end
            else
            begin
                alive = ($urandom_range(99) >= 12);
                port = ($urandom_range(99) >= 12);
                r = $urandom_range(99);
                if (r < 30)
                    clients = 8'd0;
                else if (r < 40)
                    clients = 8'hFF;
                else
                    clients = 8'($urandom_range(254, 1));
            end
            queue_check(alive, port, clients, ts_now);
        end
    endtask

    task automatic wait_idle();
        while (pending_checks.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_AUTO_RECOVER_EN: regs.auto_recover_en = data[0];
            CFG_WINDOW_SECONDS:  regs.window_seconds = data;
            CFG_MAX_RESTARTS:    regs.max_restarts = data[7:0];
            CFG_CLIENT_TIMEOUT:  regs.client_timeout_seconds = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [15:0] en, input logic [15:0] win,
                             input logic [15:0] lim, input logic [15:0] tmo);
        wait_idle();
        repeat (4) @(posedge clk);
        write_reg(CFG_AUTO_RECOVER_EN, en);
        write_reg(CFG_WINDOW_SECONDS, win);
        write_reg(CFG_MAX_RESTARTS, lim);
        write_reg(CFG_CLIENT_TIMEOUT, tmo);
    endtask

    initial
    begin
        latch_by_refusal = 1'($urandom_range(1, 0));
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset configuration: recovery off
        queue_check(1'b1, 1'b1, 8'hFF, 32'd0);
        queue_check(1'b0, 1'b0, 8'd0, 32'hFFFF_FFFF);
        queue_check(1'b1, 1'b0, 8'd0, 32'd0);

        write_all(16'd1, 16'd10, 16'd255, 16'd5);
        queue_check(1'b0, 1'b1, 8'd1, 32'd100);
        queue_check(1'b1, 1'b0, 8'd1, 32'd100);
        queue_check(1'b1, 1'b1, 8'd0, 32'd101);
        queue_check(1'b1, 1'b1, 8'd0, 32'd103);
        queue_check(1'b1, 1'b1, 8'd0, 32'd106);
        queue_check(1'b1, 1'b1, 8'd0, 32'd107);
        queue_check(1'b1, 1'b1, 8'd3, 32'd108);
        queue_check(1'b1, 1'b1, 8'd0, 32'd109);
        // timestamp going backwards counts as a long elapsed time
        queue_check(1'b1, 1'b1, 8'd0, 32'd50);
        queue_check(1'b0, 1'b0, 8'hFF, 32'hFFFF_FFFF);
        queue_check(1'b0, 1'b1, 8'd0, 32'd0);
        queue_check(1'b1, 1'b1, 8'hFF, 32'd0);

        write_all(16'd1, 16'd1, 16'd255, 16'd1);
        queue_random(150);

        // long receiver hold while checks keep coming
        write_all(16'd1, 16'hFFFF, 16'd255, 16'hFFFF);
        stall_req = ~stall_req;
        queue_random(120);

        // default window and timeout, no idling on either side
        write_all(16'd1, 16'd0, 16'd255, 16'd0);
        src_idle = 0;
        sink_idle = 0;
        queue_random(60);
        wait_idle();
        queue_random(60);
        wait_idle();
        src_idle = 21;
        sink_idle = 21;

        // upper data bits dropped: enable reads as off
        write_all(16'hFFFE, 16'd7, 16'd20, 16'd3);
        write_reg(CFG_INDEX_UNUSED, 16'hFFFF);
        queue_random(50);

        if (latch_by_refusal)
        begin
            write_all(16'd1, 16'hFFFF, 16'd255, 16'd0);
            ts_now = ts_now + 32'd1;
            repeat (5) queue_check(1'b0, 1'b1, 8'd9, ts_now);
            // default limit below the current count refuses the next attempt
            write_all(16'd1, 16'd0, 16'd0, 16'd0);
            queue_check(1'b1, 1'b0, 8'd7, ts_now);
            queue_random(140);
        end
        else
        begin
            write_all(16'd1, 16'd0, 16'd1, 16'd0);
            queue_random(150);
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
design/rlrs_pkg.sv
design/rlrs_step.sv
design/rate_limited_recovery_supervisor_unit.sv
test/tb_rate_limited_recovery_supervisor_unit.sv
